// ----- rtl/core/pwd_pkg.sv -----
// ----------------------------------------------------------------------------
// pwd_pkg
// Shared widths, types and the arctangent table for the winding direction
// block.
// ----------------------------------------------------------------------------
package pwd_pkg;

    localparam int COORD_WIDTH   = 24;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int CW        = COORD_WIDTH + 4;
    localparam int ZW        = 32;
    localparam int SHIFT_W   = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int TURN_W    = 32;

    localparam logic signed [TURN_W-1:0] TURN_LIMIT =
        TURN_W'((2 ** ANGLE_WIDTH) + ((2 ** ANGLE_WIDTH) + 100) / 200);
    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
    localparam logic [ZW-1:0] HALF_TURN = {1'b1, {(ZW-1){1'b0}}};
    localparam logic [ZW-1:0] ROUND_HALF = ZW'(1) << (ZW - 1 - ANGLE_WIDTH);

    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ZW-1:0]        z;
    } cell_t;

    typedef struct packed {
        logic                   valid;
        logic                   last;
        logic [ANGLE_WIDTH-1:0] heading;
    } hdg_t;

    function automatic logic [ZW-1:0] atan_entry(input logic [SHIFT_W-1:0] idx);
        logic [ZW-1:0] r;
        unique case (5'(idx))
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10679838;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/pwd_seg_if.sv -----
// ----------------------------------------------------------------------------
// pwd_seg_if
// Segment channel: one item per polygon edge.
// ----------------------------------------------------------------------------
interface pwd_seg_if;
    import pwd_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic                          last_segment;

    modport source (output valid, start_x, start_y, end_x, end_y, last_segment,
                    input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, last_segment,
                    output ready);
endinterface

// ----- rtl/core/pwd_res_if.sv -----
// ----------------------------------------------------------------------------
// pwd_res_if
// Result channel: one item per closed polygon.
// ----------------------------------------------------------------------------
interface pwd_res_if;
    import pwd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     clockwise;
    logic signed [TURN_W-1:0] total_turn;
    logic                     turn_out_of_range;

    modport source (output valid, clockwise, total_turn, turn_out_of_range,
                    input ready);
    modport sink   (input valid, clockwise, total_turn, turn_out_of_range,
                    output ready);
endinterface

// ----- rtl/core/pwd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pwd_cfg_if
// Configuration write channel for the y axis orientation register.
// ----------------------------------------------------------------------------
interface pwd_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/polygon_winding_direction_top.sv -----
// Result path: the last accepted segment passes the front register, the chain
// of CORDIC cells and the result register; other segments give no result.
// Throughput: one segment per cycle through the chain of CORDIC cells; the
// whole chain holds while a result waits in the output register.
// Reset: asynchronous active low; clears the pipeline, the turn state and sets
// y_axis_down to 1.
// ----------------------------------------------------------------------------
// polygon_winding_direction_top
// Winding direction of a closed polygon from the sum of its heading changes.
// ----------------------------------------------------------------------------
module polygon_winding_direction_top (
    input  logic       clk,
    input  logic       rst_n,
    pwd_seg_if.sink    seg,
    pwd_res_if.source  res,
    pwd_cfg_if.sink    cfg
);
    import pwd_pkg::*;

    logic y_axis_down_reg;
    logic advance;
    hdg_t hdg;

    assign advance   = !res.valid || res.ready;
    assign seg.ready = advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_axis_down_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            y_axis_down_reg <= cfg.data;
        end
    end

    pwd_heading u_heading (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_valid     (seg.valid),
        .start_x      (seg.start_x),
        .start_y      (seg.start_y),
        .end_x        (seg.end_x),
        .end_y        (seg.end_y),
        .last_segment (seg.last_segment),
        .hdg          (hdg)
    );

    pwd_turn_accum u_accum (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (advance),
        .hdg               (hdg),
        .y_axis_down       (y_axis_down_reg),
        .res_ready         (res.ready),
        .res_valid         (res.valid),
        .clockwise         (res.clockwise),
        .total_turn        (res.total_turn),
        .turn_out_of_range (res.turn_out_of_range)
    );
endmodule

// ----- rtl/core/pwd_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// pwd_cordic_cell
// One vectoring CORDIC iteration with its own pipeline register.
// ----------------------------------------------------------------------------
module pwd_cordic_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [pwd_pkg::SHIFT_W-1:0] stage,
    input  pwd_pkg::cell_t         din,
    output pwd_pkg::cell_t         dout
);
    import pwd_pkg::*;

    cell_t                dout_reg;
    cell_t                dout_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = din.x >>> stage;
    assign ys = din.y >>> stage;

    always_comb
    begin
        dout_next = din;
        if (!din.y[CW-1])
        begin
            dout_next.x = din.x + ys;
            dout_next.y = din.y - xs;
            dout_next.z = din.z + atan_entry(stage);
        end
        else
        begin
            dout_next.x = din.x - ys;
            dout_next.y = din.y + xs;
            dout_next.z = din.z - atan_entry(stage);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else if (advance)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;
endmodule

// ----- rtl/core/pwd_heading.sv -----
// ----------------------------------------------------------------------------
// pwd_heading
// Segment heading: difference and half-plane fold, then a chain of CORDIC
// cells, then rounding to a binary angle.
// ----------------------------------------------------------------------------
module pwd_heading (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 in_valid,
    input  logic signed [pwd_pkg::COORD_WIDTH-1:0] start_x,
    input  logic signed [pwd_pkg::COORD_WIDTH-1:0] start_y,
    input  logic signed [pwd_pkg::COORD_WIDTH-1:0] end_x,
    input  logic signed [pwd_pkg::COORD_WIDTH-1:0] end_y,
    input  logic                                 last_segment,
    output pwd_pkg::hdg_t                        hdg
);
    import pwd_pkg::*;

    cell_t                front_reg;
    cell_t                front_next;
    cell_t                chain [CORDIC_STAGES+1];
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic [ZW-1:0]        z_round;

    assign dx = CW'(end_x) - CW'(start_x);
    assign dy = CW'(end_y) - CW'(start_y);

    always_comb
    begin
        front_next.valid = in_valid;
        front_next.last  = last_segment;
        front_next.zero  = (dx == '0) && (dy == '0);
        if (dx[CW-1])
        begin
            front_next.x = -dx;
            front_next.y = -dy;
            front_next.z = HALF_TURN;
        end
        else
        begin
            front_next.x = dx;
            front_next.y = dy;
            front_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else if (advance)
        begin
            front_reg <= front_next;
        end
    end

    assign chain[0] = front_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        pwd_cordic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .stage   (SHIFT_W'(i)),
            .din     (chain[i]),
            .dout    (chain[i+1])
        );
    end

    assign z_round     = chain[CORDIC_STAGES].z + ROUND_HALF;
    assign hdg.valid   = chain[CORDIC_STAGES].valid;
    assign hdg.last    = chain[CORDIC_STAGES].last;
    assign hdg.heading = chain[CORDIC_STAGES].zero ? '0
                                                   : z_round[ZW-1 -: ANGLE_WIDTH];
endmodule

// ----- rtl/core/pwd_turn_accum.sv -----
// ----------------------------------------------------------------------------
// pwd_turn_accum
// Wrapped heading change, saturating turn total and the result register.
// ----------------------------------------------------------------------------
module pwd_turn_accum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  pwd_pkg::hdg_t      hdg,
    input  logic               y_axis_down,
    input  logic               res_ready,
    output logic               res_valid,
    output logic               clockwise,
    output logic signed [pwd_pkg::TURN_W-1:0] total_turn,
    output logic               turn_out_of_range
);
    import pwd_pkg::*;

    logic [ANGLE_WIDTH-1:0]    first_reg;
    logic [ANGLE_WIDTH-1:0]    prev_reg;
    logic signed [TURN_W-1:0]  acc_reg;
    logic                      inside_reg;
    logic                      res_valid_reg;
    logic signed [TURN_W-1:0]  total_reg;

    logic [ANGLE_WIDTH-1:0]    first_used;
    logic [ANGLE_WIDTH-1:0]    d_step;
    logic [ANGLE_WIDTH-1:0]    d_close;
    logic signed [TURN_W:0]    sum_step;
    logic signed [TURN_W:0]    sum_close;
    logic signed [TURN_W-1:0]  acc_step;
    logic signed [TURN_W-1:0]  acc_close;
    logic                      take;

    function automatic logic signed [TURN_W-1:0] sat(input logic signed [TURN_W:0] s);
        logic signed [TURN_W-1:0] r;
        if (s[TURN_W] != s[TURN_W-1])
            r = s[TURN_W] ? TURN_MIN : TURN_MAX;
        else
            r = s[TURN_W-1:0];
        return r;
    endfunction

    assign take       = advance && hdg.valid;
    assign first_used = inside_reg ? first_reg : hdg.heading;

    // half turn exactly wraps to minus a half turn
    assign d_step  = hdg.heading - prev_reg;
    assign d_close = first_used - hdg.heading;

    assign sum_step  = inside_reg ? ((TURN_W+1)'(acc_reg) + (TURN_W+1)'(signed'(d_step)))
                                  : '0;
    assign acc_step  = sat(sum_step);
    assign sum_close = (TURN_W+1)'(acc_step) + (TURN_W+1)'(signed'(d_close));
    assign acc_close = sat(sum_close);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            prev_reg      <= '0;
            acc_reg       <= '0;
            inside_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (take)
            begin
                if (hdg.last)
                begin
                    first_reg     <= '0;
                    prev_reg      <= '0;
                    acc_reg       <= '0;
                    inside_reg    <= 1'b0;
                    res_valid_reg <= 1'b1;
                end
                else
                begin
                    first_reg  <= first_used;
                    prev_reg   <= hdg.heading;
                    acc_reg    <= acc_step;
                    inside_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && hdg.last)
        begin
            total_reg <= acc_close;
        end
    end

    assign res_valid         = res_valid_reg;
    assign total_turn        = total_reg;
    assign clockwise         = y_axis_down ? !total_reg[TURN_W-1] : total_reg[TURN_W-1];
    assign turn_out_of_range = (total_reg > TURN_LIMIT) || (total_reg < -TURN_LIMIT);
endmodule
